@@ src/fpr_pkg.sv @@
// Shared constants and types for the framed packet receiver.
// Used by fpr_store, fpr_ctrl and framed_packet_receiver_top; no dependencies.
package fpr_pkg;

  localparam int unsigned MaxPayload = 16;
  localparam int unsigned AddrW      = $clog2(MaxPayload);
  localparam int unsigned CntW       = $clog2(MaxPayload + 1);
  localparam int unsigned LenW       = 5;
  localparam int unsigned TickW      = 16;
  localparam int unsigned OutDataW   = 32;

  localparam logic [7:0]       StartByte    = 8'hAA;
  localparam logic [7:0]       EndByte      = 8'h55;
  localparam logic [TickW-1:0] TimeoutReset = 16'd10000;

  localparam logic KindByte = 1'b0;
  localparam logic KindTick = 1'b1;

  localparam logic OutData   = 1'b0;
  localparam logic OutStatus = 1'b1;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StBad     = 2'd1;
  localparam logic [1:0] StTimeout = 2'd2;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } fpr_store_req_t;

  typedef struct packed {
    logic            okind;
    logic [7:0]      data;
    logic [1:0]      status;
    logic [7:0]      ptype;
    logic [LenW-1:0] plen;
    logic [7:0]      pchk;
    logic            last;
  } fpr_result_t;

endpackage

@@ src/fpr_store.sv @@
// Payload store: one write port and one registered read port.
// Depends on fpr_pkg for the depth and the request struct.
module fpr_store import fpr_pkg::*; (
  input  logic           clk_i,
  input  fpr_store_req_t req_i,
  output logic [7:0]     rdata_o
);

  logic [7:0] mem [MaxPayload];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/fpr_ctrl.sv @@
// Frame parser, checksum, timeout and result sequencer with its output register.
// Depends on fpr_pkg; drives the payload store through fpr_store_req_t.
module fpr_ctrl import fpr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [TickW-1:0] timeout_i,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  logic             s_kind_i,
  input  logic [7:0]       s_byte_i,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output fpr_result_t      m_result_o,
  output fpr_store_req_t   store_req_o,
  input  logic [7:0]       store_rdata_i
);

  localparam logic [2:0] PhHunt  = 3'd0;
  localparam logic [2:0] PhType  = 3'd1;
  localparam logic [2:0] PhLen   = 3'd2;
  localparam logic [2:0] PhData  = 3'd3;
  localparam logic [2:0] PhCheck = 3'd4;
  localparam logic [2:0] PhEnd   = 3'd5;

  localparam logic [1:0] MdParse  = 2'd0;
  localparam logic [1:0] MdRead   = 2'd1;
  localparam logic [1:0] MdLoad   = 2'd2;
  localparam logic [1:0] MdStatus = 2'd3;

  localparam logic [7:0]      MaxPayloadB = 8'(MaxPayload);
  localparam logic [CntW-1:0] MaxCnt      = CntW'(MaxPayload);

  logic [2:0]       phase_q, phase_d;
  logic [1:0]       mode_q, mode_d;
  logic [7:0]       type_q, type_d;
  logic [CntW-1:0]  len_q, len_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [7:0]       xor_q, xor_d;
  logic [7:0]       chk_q, chk_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic             ovalid_q, ovalid_d;
  fpr_result_t      res_q, res_d;

  logic             out_free;
  logic             accept;
  logic [TickW-1:0] tick_inc;
  logic             good;

  assign out_free  = !ovalid_q || m_ready_i;
  assign s_ready_o = (mode_q == MdParse) &&
                     (out_free || (s_kind_i == KindByte && phase_q != PhEnd));
  assign accept    = s_valid_i && s_ready_o;
  assign tick_inc  = (tick_q == '1) ? tick_q : tick_q + TickW'(1);
  assign good      = (s_byte_i == EndByte) && (xor_q == chk_q);

  always_comb begin
    phase_d  = phase_q;
    mode_d   = mode_q;
    type_d   = type_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    xor_d    = xor_q;
    chk_d    = chk_q;
    tick_d   = tick_q;
    rd_idx_d = rd_idx_q;
    ovalid_d = ovalid_q;
    res_d    = res_q;
    store_req_o       = '0;
    store_req_o.waddr = cnt_q[AddrW-1:0];
    store_req_o.wdata = s_byte_i;
    store_req_o.raddr = rd_idx_q[AddrW-1:0];

    if (ovalid_q && m_ready_i) begin
      ovalid_d = 1'b0;
    end

    unique case (mode_q)
      MdParse: begin
        if (accept && s_kind_i == KindTick) begin
          if (phase_q != PhHunt) begin
            if (tick_inc >= timeout_i) begin
              res_d    = '{okind: OutStatus, data: 8'd0, status: StTimeout, ptype: 8'd0,
                           plen: '0, pchk: 8'd0, last: 1'b1};
              ovalid_d = 1'b1;
              phase_d  = PhHunt;
              tick_d   = '0;
            end else begin
              tick_d = tick_inc;
            end
          end
        end else if (accept) begin
          unique case (phase_q)
            PhHunt: begin
              if (s_byte_i == StartByte) begin
                phase_d = PhType;
                tick_d  = '0;
                xor_d   = 8'd0;
                cnt_d   = '0;
              end
            end
            PhType: begin
              type_d  = s_byte_i;
              phase_d = PhLen;
            end
            PhLen: begin
              len_d   = (s_byte_i > MaxPayloadB) ? MaxCnt : CntW'(s_byte_i);
              cnt_d   = '0;
              xor_d   = 8'd0;
              phase_d = (s_byte_i == 8'd0) ? PhCheck : PhData;
            end
            PhData: begin
              store_req_o.we = (cnt_q < MaxCnt);
              xor_d          = xor_q ^ s_byte_i;
              cnt_d          = cnt_q + CntW'(1);
              if (cnt_d >= len_q) begin
                phase_d = PhCheck;
              end
            end
            PhCheck: begin
              chk_d   = s_byte_i;
              phase_d = PhEnd;
            end
            PhEnd: begin
              if (good && len_q != '0) begin
                mode_d   = MdRead;
                rd_idx_d = '0;
              end else begin
                res_d    = '{okind: OutStatus, data: 8'd0, status: good ? StOk : StBad,
                             ptype: type_q, plen: LenW'(len_q), pchk: chk_q, last: 1'b1};
                ovalid_d = 1'b1;
              end
              phase_d = PhHunt;
              tick_d  = '0;
            end
            default: begin
              phase_d = PhHunt;
              tick_d  = '0;
            end
          endcase
        end
      end
      MdRead: begin
        store_req_o.re = 1'b1;
        mode_d         = MdLoad;
      end
      MdLoad: begin
        if (out_free) begin
          res_d    = '{okind: OutData, data: store_rdata_i, status: StOk, ptype: type_q,
                       plen: LenW'(len_q), pchk: chk_q, last: 1'b0};
          ovalid_d = 1'b1;
          rd_idx_d = rd_idx_q + CntW'(1);
          mode_d   = (rd_idx_d >= len_q) ? MdStatus : MdRead;
        end
      end
      MdStatus: begin
        if (out_free) begin
          res_d    = '{okind: OutStatus, data: 8'd0, status: StOk, ptype: type_q,
                       plen: LenW'(len_q), pchk: chk_q, last: 1'b1};
          ovalid_d = 1'b1;
          mode_d   = MdParse;
        end
      end
      default: begin
        mode_d = MdParse;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt;
      mode_q   <= MdParse;
      type_q   <= 8'd0;
      len_q    <= '0;
      cnt_q    <= '0;
      xor_q    <= 8'd0;
      chk_q    <= 8'd0;
      tick_q   <= '0;
      rd_idx_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      mode_q   <= mode_d;
      type_q   <= type_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      xor_q    <= xor_d;
      chk_q    <= chk_d;
      tick_q   <= tick_d;
      rd_idx_q <= rd_idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_valid_o  = ovalid_q;
  assign m_result_o = res_q;

endmodule

@@ src/framed_packet_receiver_top.sv @@
// Each accepted byte or tick leaves at most one status result straight away. A good frame
// with a nonempty payload is replayed from the payload store after its end byte, each byte
// through a read state and a load state because of the store's registered read port, then
// a status result; no input is taken during that replay. Ticks and end bytes wait while the
// output register is full and not being taken. The timeout register resets to 10000 ticks.
module framed_packet_receiver_top import fpr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [TickW-1:0]    cfg_data_i,     // timeout_ticks
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // rx_byte
  input  logic                s_axis_tuser,   // kind
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // data_byte, status, packet_type,
                                              // packet_length, packet_checksum, zero pad
  output logic                m_axis_tuser,   // out_kind
  output logic                m_axis_tlast
);

  logic [TickW-1:0] timeout_q;
  fpr_store_req_t   store_req;
  logic [7:0]       store_rdata;
  fpr_result_t      result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_valid_i) begin
      timeout_q <= cfg_data_i;
    end
  end

  fpr_store u_store (
    .clk_i   (clk_i),
    .req_i   (store_req),
    .rdata_o (store_rdata)
  );

  fpr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .timeout_i     (timeout_q),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .s_kind_i      (s_axis_tuser),
    .s_byte_i      (s_axis_tdata),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_result_o    (result),
    .store_req_o   (store_req),
    .store_rdata_i (store_rdata)
  );

  assign m_axis_tdata = {1'b0, result.pchk, result.plen, result.ptype, result.status,
                         result.data};
  assign m_axis_tuser = result.okind;
  assign m_axis_tlast = result.last;

  a_timeout_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && result.status == StTimeout) |->
      (result.okind == OutStatus && result.ptype == 8'd0 && result.plen == '0 &&
       result.pchk == 8'd0 && result.last))
    else $error("timeout result carries frame fields");

  a_data_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && result.okind == OutData) |-> (!result.last && result.status == StOk))
    else $error("data result marked last or with a status");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (result.plen <= LenW'(MaxPayload)))
    else $error("packet length above the maximum payload");

  a_no_input_in_replay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && result.okind == OutData && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while a payload replay is pending");

endmodule
